// File: src/hsct_pkg.sv
// shared widths, item and stage types for the collision time predictor
// no dependencies; compiled first
package hsct_pkg;

  localparam int POS_W  = 31;
  localparam int VEL_W  = 32;
  localparam int RAD_W  = 28;
  localparam int TIME_W = 48;

  localparam int DR_W   = 32;   // relative position, signed
  localparam int DV_W   = 33;   // relative velocity, signed
  localparam int RS_W   = 29;   // radius sum, unsigned
  localparam int A_W    = 67;   // dv.dv, unsigned
  localparam int B_W    = 66;   // dv.dr, signed
  localparam int C_W    = 65;   // dr.dr - rs^2, signed
  localparam int DM_W   = 134;  // non-negative discriminant
  localparam int D_W    = 135;  // signed discriminant
  localparam int ROOT_W = 68;   // integer square root
  localparam int SQ_W   = 137;  // square root trial width
  localparam int N_W    = 69;   // signed numerator -b - s
  localparam int NP_W   = 68;   // positive numerator
  localparam int FRAC_SH = 20;  // numerator scale 2^20
  localparam int HI_SH  = TIME_W - FRAC_SH;  // 28
  localparam int REM_W  = A_W;

  typedef struct packed {
    logic              op;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [VEL_W-1:0]  vel_x;
    logic [VEL_W-1:0]  vel_y;
    logic [VEL_W-1:0]  vel_z;
    logic [RAD_W-1:0]  radius;
  } in_item_t;

  typedef struct packed {
    logic              nohit;
    logic [A_W-1:0]    a;
    logic [B_W-1:0]    b;
    logic [DM_W-1:0]   d;
  } sq_in_t;

  typedef struct packed {
    logic              nohit;
    logic [A_W-1:0]    a;
    logic [B_W-1:0]    b;
    logic [ROOT_W-1:0] root;
    logic [DM_W-1:0]   rem;
  } sq_state_t;

  typedef struct packed {
    logic              nohit;
    logic [A_W-1:0]    a;
    logic [B_W-1:0]    b;
    logic [ROOT_W-1:0] root;
  } sq_out_t;

  typedef struct packed {
    logic              nohit;
    logic              ovf;
    logic [A_W-1:0]    a;
    logic [REM_W-1:0]  rem;
    logic [TIME_W-1:0] bits;
    logic [TIME_W-1:0] q;
  } div_state_t;

endpackage

// File: src/hsct_if.sv
// valid/ready channel interfaces for particle items and results
// depends on hsct_pkg
interface hsct_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [hsct_pkg::POS_W-1:0] pos_x;
  logic [hsct_pkg::POS_W-1:0] pos_y;
  logic [hsct_pkg::POS_W-1:0] pos_z;
  logic [hsct_pkg::VEL_W-1:0] vel_x;
  logic [hsct_pkg::VEL_W-1:0] vel_y;
  logic [hsct_pkg::VEL_W-1:0] vel_z;
  logic [hsct_pkg::RAD_W-1:0] radius;

  modport source (output valid, op, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius,
                output ready);
endinterface

interface hsct_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [hsct_pkg::TIME_W-1:0] time_to_hit;

  modport source (output valid, hit, time_to_hit, input ready);
  modport sink (input valid, hit, time_to_hit, output ready);
endinterface

// File: src/hsct_front.sv
// reference particle store and stages forming dr, dv, a, b, c and the discriminant
// depends on hsct_pkg
module hsct_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_fire,
  input  hsct_pkg::in_item_t in_item,
  output logic              out_valid,
  output hsct_pkg::sq_in_t  out_item
);
  import hsct_pkg::*;

  logic [POS_W-1:0] ref_pos_x_r, ref_pos_y_r, ref_pos_z_r;
  logic [VEL_W-1:0] ref_vel_x_r, ref_vel_y_r, ref_vel_z_r;
  logic [RAD_W-1:0] ref_radius_r;

  logic [5:0] vld_r;

  // stage 1
  logic signed [DR_W-1:0] dr_x_r, dr_y_r, dr_z_r;
  logic signed [DV_W-1:0] dv_x_r, dv_y_r, dv_z_r;
  logic [RS_W-1:0]        rs_r;
  logic signed [DR_W-1:0] dr_x_nxt, dr_y_nxt, dr_z_nxt;
  logic signed [DV_W-1:0] dv_x_nxt, dv_y_nxt, dv_z_nxt;
  // stage 2
  logic signed [65:0] paa_x_r, paa_y_r, paa_z_r;
  logic signed [64:0] pab_x_r, pab_y_r, pab_z_r;
  logic signed [63:0] pbb_x_r, pbb_y_r, pbb_z_r;
  logic [57:0]        rs2_r;
  // stage 3
  logic [A_W-1:0] a3_r;
  logic [B_W-1:0] b3_r;
  logic [C_W-1:0] c3_r;
  // stage 4
  logic [A_W-1:0] a4_r;
  logic [B_W-1:0] b4_r;
  logic           cneg4_r;
  logic [65:0]    pbll_r, pblh_r, pbhh_r;
  logic [65:0]    pacll_r, paclh_r;
  logic [64:0]    pachl_r, pachh_r;
  logic [B_W-1:0] bmag;
  logic [C_W-1:0] cneg_val;
  logic [63:0]    cmag;
  // stage 5
  logic [A_W-1:0]  a5_r;
  logic [B_W-1:0]  b5_r;
  logic            cneg5_r;
  logic [DM_W-1:0] b2_r, ac_r;
  // stage 6
  logic [A_W-1:0]  a6_r;
  logic [B_W-1:0]  b6_r;
  logic            nohit6_r;
  logic [DM_W-1:0] d6_r;
  logic [D_W-1:0]  d_full;

  // reference particle update on a load item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_pos_x_r  <= '0;
      ref_pos_y_r  <= '0;
      ref_pos_z_r  <= '0;
      ref_vel_x_r  <= '0;
      ref_vel_y_r  <= '0;
      ref_vel_z_r  <= '0;
      ref_radius_r <= '0;
    end else if (in_fire && !in_item.op) begin
      ref_pos_x_r  <= in_item.pos_x;
      ref_pos_y_r  <= in_item.pos_y;
      ref_pos_z_r  <= in_item.pos_z;
      ref_vel_x_r  <= in_item.vel_x;
      ref_vel_y_r  <= in_item.vel_y;
      ref_vel_z_r  <= in_item.vel_z;
      ref_radius_r <= in_item.radius;
    end
  end

  // valid bits, only test items enter the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_fire & in_item.op};
    end
  end

  // relative position and velocity
  always_comb begin
    dr_x_nxt = $signed({1'b0, in_item.pos_x}) - $signed({1'b0, ref_pos_x_r});
    dr_y_nxt = $signed({1'b0, in_item.pos_y}) - $signed({1'b0, ref_pos_y_r});
    dr_z_nxt = $signed({1'b0, in_item.pos_z}) - $signed({1'b0, ref_pos_z_r});
    dv_x_nxt = $signed({in_item.vel_x[VEL_W-1], in_item.vel_x})
             - $signed({ref_vel_x_r[VEL_W-1], ref_vel_x_r});
    dv_y_nxt = $signed({in_item.vel_y[VEL_W-1], in_item.vel_y})
             - $signed({ref_vel_y_r[VEL_W-1], ref_vel_y_r});
    dv_z_nxt = $signed({in_item.vel_z[VEL_W-1], in_item.vel_z})
             - $signed({ref_vel_z_r[VEL_W-1], ref_vel_z_r});
  end

  // magnitudes for the wide products
  always_comb begin
    bmag     = b3_r[B_W-1] ? (B_W'(0) - b3_r) : b3_r;
    cneg_val = C_W'(0) - c3_r;
    cmag     = c3_r[C_W-1] ? cneg_val[63:0] : c3_r[63:0];
  end

  // signed discriminant
  always_comb begin
    if (cneg5_r) begin
      d_full = D_W'(b2_r) + D_W'(ac_r);
    end else begin
      d_full = D_W'(b2_r) - D_W'(ac_r);
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      dr_x_r <= dr_x_nxt;
      dr_y_r <= dr_y_nxt;
      dr_z_r <= dr_z_nxt;
      dv_x_r <= dv_x_nxt;
      dv_y_r <= dv_y_nxt;
      dv_z_r <= dv_z_nxt;
      rs_r   <= RS_W'(in_item.radius) + RS_W'(ref_radius_r);

      paa_x_r <= dv_x_r * dv_x_r;
      paa_y_r <= dv_y_r * dv_y_r;
      paa_z_r <= dv_z_r * dv_z_r;
      pab_x_r <= dv_x_r * dr_x_r;
      pab_y_r <= dv_y_r * dr_y_r;
      pab_z_r <= dv_z_r * dr_z_r;
      pbb_x_r <= dr_x_r * dr_x_r;
      pbb_y_r <= dr_y_r * dr_y_r;
      pbb_z_r <= dr_z_r * dr_z_r;
      rs2_r   <= rs_r * rs_r;

      a3_r <= {2'b0, paa_x_r[64:0]} + {2'b0, paa_y_r[64:0]} + {2'b0, paa_z_r[64:0]};
      b3_r <= {pab_x_r[64], pab_x_r} + {pab_y_r[64], pab_y_r} + {pab_z_r[64], pab_z_r};
      c3_r <= {2'b0, pbb_x_r[62:0]} + {2'b0, pbb_y_r[62:0]} + {2'b0, pbb_z_r[62:0]}
            - {7'b0, rs2_r};

      a4_r    <= a3_r;
      b4_r    <= b3_r;
      cneg4_r <= c3_r[C_W-1];
      pbll_r  <= bmag[32:0] * bmag[32:0];
      pblh_r  <= bmag[32:0] * bmag[65:33];
      pbhh_r  <= bmag[65:33] * bmag[65:33];
      pacll_r <= a3_r[33:0] * cmag[31:0];
      paclh_r <= a3_r[33:0] * cmag[63:32];
      pachl_r <= a3_r[66:34] * cmag[31:0];
      pachh_r <= a3_r[66:34] * cmag[63:32];

      a5_r    <= a4_r;
      b5_r    <= b4_r;
      cneg5_r <= cneg4_r;
      b2_r    <= (DM_W'(pbhh_r) << 66) + (DM_W'(pblh_r) << 34) + DM_W'(pbll_r);
      ac_r    <= (DM_W'(pachh_r) << 66) + (DM_W'(pachl_r) << 34)
               + (DM_W'(paclh_r) << 32) + DM_W'(pacll_r);

      a6_r     <= a5_r;
      b6_r     <= b5_r;
      nohit6_r <= (a5_r == '0) || d_full[D_W-1] || !b5_r[B_W-1];
      d6_r     <= d_full[D_W-1] ? '0 : d_full[DM_W-1:0];
    end
  end

  assign out_valid      = vld_r[5];
  assign out_item.nohit = nohit6_r;
  assign out_item.a     = a6_r;
  assign out_item.b     = b6_r;
  assign out_item.d     = d6_r;

endmodule

// File: src/hsct_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on hsct_pkg
module hsct_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  hsct_pkg::sq_in_t  in_item,
  output logic              out_valid,
  output hsct_pkg::sq_out_t out_item
);
  import hsct_pkg::*;

  logic [ROOT_W:0] vld;
  sq_state_t       st [0:ROOT_W];

  // stage zero takes the discriminant as the running remainder
  assign vld[0]      = in_valid;
  assign st[0].nohit = in_item.nohit;
  assign st[0].a     = in_item.a;
  assign st[0].b     = in_item.b;
  assign st[0].root  = '0;
  assign st[0].rem   = in_item.d;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    localparam int I = ROOT_W - 1 - k;
    logic [SQ_W-1:0] trial;
    logic            ge;
    sq_state_t       nxt;

    // try setting root bit I: subtract root*2^(I+1) + 2^(2I)
    always_comb begin
      trial = ({{(SQ_W-ROOT_W){1'b0}}, st[k].root} << (I + 1)) | (SQ_W'(1) << (2 * I));
      ge    = {{(SQ_W-DM_W){1'b0}}, st[k].rem} >= trial;
      nxt   = st[k];
      if (ge) begin
        nxt.rem  = st[k].rem - trial[DM_W-1:0];
        nxt.root = st[k].root | (ROOT_W'(1) << I);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign out_valid      = vld[ROOT_W];
  assign out_item.nohit = st[ROOT_W].nohit;
  assign out_item.a     = st[ROOT_W].a;
  assign out_item.b     = st[ROOT_W].b;
  assign out_item.root  = st[ROOT_W].root;

endmodule

// File: src/hsct_div.sv
// numerator forming and pipelined restoring divider, one quotient bit per stage
// depends on hsct_pkg
module hsct_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  hsct_pkg::sq_out_t            in_item,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [hsct_pkg::TIME_W-1:0]  out_time
);
  import hsct_pkg::*;

  logic [TIME_W:0] vld;
  div_state_t      st [0:TIME_W];

  logic [N_W-1:0]    num;
  logic [NP_W-1:0]   npos;
  logic [NP_W-HI_SH-1:0] hi;
  div_state_t        st0_nxt;

  // numerator n = -b - s, overflow when (n * 2^20) >> 48 reaches a
  always_comb begin
    num  = N_W'(0) - {{(N_W-B_W){in_item.b[B_W-1]}}, in_item.b}
         - {{(N_W-ROOT_W){1'b0}}, in_item.root};
    npos = num[NP_W-1:0];
    hi   = npos[NP_W-1:HI_SH];
    st0_nxt.nohit = in_item.nohit || num[N_W-1] || (num == '0);
    st0_nxt.ovf   = {{(A_W-(NP_W-HI_SH)){1'b0}}, hi} >= in_item.a;
    st0_nxt.a     = in_item.a;
    st0_nxt.rem   = REM_W'(hi);
    st0_nxt.bits  = {npos[HI_SH-1:0], {FRAC_SH{1'b0}}};
    st0_nxt.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_nxt;
    end
  end

  for (genvar j = 0; j < TIME_W; j++) begin : g_step
    logic [REM_W:0] sh;
    logic           ge;
    div_state_t     nxt;

    // shift in the next numerator bit and subtract the divisor when it fits
    always_comb begin
      sh       = {st[j].rem, st[j].bits[TIME_W-1]};
      ge       = sh >= {1'b0, st[j].a};
      nxt      = st[j];
      nxt.bits = {st[j].bits[TIME_W-2:0], 1'b0};
      nxt.q    = {st[j].q[TIME_W-2:0], ge};
      if (ge) begin
        nxt.rem = REM_W'(sh - {1'b0, st[j].a});
      end else begin
        nxt.rem = sh[REM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j+1] <= nxt;
      end
    end
  end

  // final result, saturated or no-hit times read all ones
  assign out_valid = vld[TIME_W];
  assign out_hit   = !st[TIME_W].nohit;
  assign out_time  = (st[TIME_W].nohit || st[TIME_W].ovf) ? '1 : st[TIME_W].q;

endmodule

// File: src/hard_sphere_collision_time.sv
// Hard-sphere collision time predictor. A load item (op = 0) replaces the
// reference particle and gives no result; each test item (op = 1) gives one
// result: hit and the contact time in unsigned Q28.20, all ones when there is
// no hit or the time saturates. One item is accepted per cycle while the
// output is not held. A test item passes in order through the difference,
// product and discriminant stages, the bit-per-stage square root, the stage
// that forms the numerator and the bit-per-stage divider. When the output is held the
// whole pipeline freezes and ready drops; nothing is lost or repeated.
// depends on hsct_pkg, hsct_if, hsct_front, hsct_sqrt, hsct_div
module hard_sphere_collision_time (
  input  logic       clk,
  input  logic       rst_n,
  hsct_in_if.sink    in_ch,
  hsct_out_if.source out_ch
);
  import hsct_pkg::*;

  logic     en;
  logic     in_fire;
  in_item_t in_item;
  logic     sq_in_valid, sq_out_valid;
  sq_in_t   sq_in;
  sq_out_t  sq_out;

  // global advance: the output register is empty or being taken
  assign en           = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign in_fire      = in_ch.valid && en;

  assign in_item.op     = in_ch.op;
  assign in_item.pos_x  = in_ch.pos_x;
  assign in_item.pos_y  = in_ch.pos_y;
  assign in_item.pos_z  = in_ch.pos_z;
  assign in_item.vel_x  = in_ch.vel_x;
  assign in_item.vel_y  = in_ch.vel_y;
  assign in_item.vel_z  = in_ch.vel_z;
  assign in_item.radius = in_ch.radius;

  hsct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .out_valid (sq_in_valid),
    .out_item  (sq_in)
  );

  hsct_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_in_valid),
    .in_item   (sq_in),
    .out_valid (sq_out_valid),
    .out_item  (sq_out)
  );

  hsct_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_out_valid),
    .in_item   (sq_out),
    .out_valid (out_ch.valid),
    .out_hit   (out_ch.hit),
    .out_time  (out_ch.time_to_hit)
  );

endmodule

// File: src/hsct_checker.sv
// port-level checks for the collision time predictor, bound to the top level
// depends on hsct_pkg and hard_sphere_collision_time
module hsct_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [hsct_pkg::TIME_W-1:0] out_time
);
  import hsct_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_time))
    else $error("held result changed");

  // a miss always reads all ones
  a_miss_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_time == {TIME_W{1'b1}})
    else $error("miss without saturated time");

  // input is refused only while a result is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stall");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind hard_sphere_collision_time hsct_checker u_hsct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit),
  .out_time  (out_ch.time_to_hit)
);
